@@ design/lzss_xor_stream_decoder_assert.svh @@
// ---------------------------------------------------------------------------
// lzss_xor_stream_decoder assertion macros
// Shorthand for the concurrent checks of the stream decoder.
// ---------------------------------------------------------------------------
`ifndef LZSS_XOR_STREAM_DECODER_ASSERT_SVH
`define LZSS_XOR_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define LZXD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lzxd: same-cycle check failed");

// Next-cycle implication, off while reset is asserted
`define LZXD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lzxd: next-cycle check failed");

`endif

@@ design/lzxd_pkg.sv @@
// ---------------------------------------------------------------------------
// lzxd_pkg
// Shared constants and types of the keyed LZSS stream decoder.
// ---------------------------------------------------------------------------
package lzxd_pkg;

    // History window
    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FILL_W     = RING_AW + 1;

    // Token format
    localparam int              LEN_W       = 5;
    localparam int              MIN_MATCH   = 3;
    localparam logic [3:0]      FLAG_TOKENS = 4'd8;

    // Register reset values
    localparam logic [7:0]         KEY_RESET  = 8'hB5;
    localparam logic [RING_AW-1:0] BIAS_RESET = RING_AW'(18);

    // Configuration port
    localparam int                APB_AW        = 3;
    localparam int                APB_DW        = 32;
    localparam logic [APB_AW-1:0] ADDR_XOR_KEY  = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_POS_BIAS = 3'd4;

    // What one input beat asks of the copy engine
    typedef enum logic [1:0] {
        CMD_NONE  = 2'b00,
        CMD_LIT   = 2'b01,
        CMD_MATCH = 2'b10
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         lit_byte;
        logic [RING_AW-1:0] pos;
        logic [LEN_W-1:0]   len;
    } cmd_t;

endpackage

@@ design/lzxd_ram.sv @@
// ---------------------------------------------------------------------------
// lzxd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lzxd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port (read returns old data on collision)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/lzxd_parser.sv @@
// ---------------------------------------------------------------------------
// lzxd_parser
// Removes the key from each input beat and walks the flag/token format,
// turning each beat into a literal, a match or nothing.
// ---------------------------------------------------------------------------
module lzxd_parser
    import lzxd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         in_byte,
    input  logic [7:0]         xor_key,
    input  logic [RING_AW-1:0] position_bias,
    output cmd_t               cmd
);

    logic [7:0] key_byte;
    logic [7:0] flag_bits_reg, flag_bits_next;
    logic [3:0] flags_left_reg, flags_left_next;
    logic       await_reg, await_next;
    logic [7:0] held_reg, held_next;

    assign key_byte = in_byte ^ xor_key;

    // Token decode
    always_comb begin
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        await_next      = await_reg;
        held_next       = held_reg;
        cmd.kind        = CMD_NONE;
        cmd.lit_byte    = key_byte;
        cmd.pos         = {key_byte[7:4], held_reg} + position_bias;
        cmd.len         = LEN_W'(key_byte[3:0]) + LEN_W'(MIN_MATCH);

        if (flags_left_reg == 4'd0) begin
            // flag byte
            flag_bits_next  = key_byte;
            flags_left_next = FLAG_TOKENS;
            await_next      = 1'b0;
        end else if (flag_bits_reg[0]) begin
            cmd.kind        = CMD_LIT;
            flag_bits_next  = flag_bits_reg >> 1;
            flags_left_next = flags_left_reg - 4'd1;
        end else if (!await_reg) begin
            // first half of a match
            held_next  = key_byte;
            await_next = 1'b1;
        end else begin
            cmd.kind        = CMD_MATCH;
            await_next      = 1'b0;
            held_next       = 8'd0;
            flag_bits_next  = flag_bits_reg >> 1;
            flags_left_next = flags_left_reg - 4'd1;
        end
    end

    // Token state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_bits_reg  <= 8'd0;
            flags_left_reg <= 4'd0;
            await_reg      <= 1'b0;
            held_reg       <= 8'd0;
        end else if (accept) begin
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            await_reg      <= await_next;
            held_reg       <= held_next;
        end
    end

endmodule

@@ design/lzss_xor_stream_decoder.sv @@
// ---------------------------------------------------------------------------
// lzss_xor_stream_decoder
// Keyed LZSS decoder with a 4096-byte history ring held in one RAM.
// ---------------------------------------------------------------------------
// Path: a literal reaches m_ through the copy-engine registers, the read-return
//   stage and the output queue. Throughput: one output byte per cycle from the ring
//   copy engine while the output queue has room; an input beat holds s_ready low
//   until all of its output bytes (0..18) are issued, m_ready stalls included.
// Reset: synchronous, active low; the ring reads as zero until written
//   (tracked by a fill count, so no clearing pass is needed).
// ---------------------------------------------------------------------------
`include "lzss_xor_stream_decoder_assert.svh"

module lzss_xor_stream_decoder
    import lzxd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // compressed input
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_in_byte,
    // decoded output
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_last_of_run
);

    logic [7:0]         xor_key_reg;
    logic [RING_AW-1:0] position_bias_reg;
    logic               cfg_wr;

    logic               s_accept;
    cmd_t               cmd;

    logic               run_active_reg, run_active_next;
    logic               run_lit_reg, run_lit_next;
    logic [7:0]         run_byte_reg, run_byte_next;
    logic [RING_AW-1:0] run_pos_reg, run_pos_next;
    logic [LEN_W-1:0]   run_left_reg, run_left_next;
    logic               credit_ok;
    logic               issue;

    logic               pend_reg;
    logic               pend_last_reg;
    logic               pend_lit_reg;
    logic [7:0]         pend_byte_reg;
    logic               pend_fwd_reg;
    logic               pend_zero_reg;

    logic [RING_AW-1:0] cursor_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [7:0]         last_byte_reg;
    logic [7:0]         ram_rdata;
    logic [7:0]         ring_byte;

    logic [7:0]         fifo_byte_reg [2];
    logic               fifo_last_reg [2];
    logic               fifo_wr_ptr_reg;
    logic               fifo_rd_ptr_reg;
    logic [1:0]         fifo_count_reg;
    logic               fifo_push;
    logic               fifo_pop;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xor_key_reg       <= KEY_RESET;
            position_bias_reg <= BIAS_RESET;
        end else if (cfg_wr) begin
            if (paddr == ADDR_XOR_KEY) begin
                xor_key_reg <= pwdata[7:0];
            end
            if (paddr == ADDR_POS_BIAS) begin
                position_bias_reg <= pwdata[RING_AW-1:0];
            end
        end
    end

    always_comb begin
        case (paddr)
            ADDR_XOR_KEY:  prdata = APB_DW'(xor_key_reg);
            ADDR_POS_BIAS: prdata = APB_DW'(position_bias_reg);
            default:       prdata = '0;
        endcase
    end

    // Input side: one beat at a time, taken while the copy engine is idle
    assign s_ready  = !run_active_reg;
    assign s_accept = s_valid && s_ready;

    lzxd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .in_byte       (s_in_byte),
        .xor_key       (xor_key_reg),
        .position_bias (position_bias_reg),
        .cmd           (cmd)
    );

    // Issue only when the output queue is sure to have room in the next cycle, when the issued byte reaches it
    assign credit_ok = ({1'b0, fifo_count_reg} + {2'b00, pend_reg})
                       <= (3'd1 + {2'b00, fifo_pop});
    assign issue     = run_active_reg && credit_ok;

    // Copy engine: one ring read (or literal slot) per issued byte
    always_comb begin
        run_active_next = run_active_reg;
        run_lit_next    = run_lit_reg;
        run_byte_next   = run_byte_reg;
        run_pos_next    = run_pos_reg;
        run_left_next   = run_left_reg;
        if (issue) begin
            run_pos_next  = run_pos_reg + RING_AW'(1);
            run_left_next = run_left_reg - LEN_W'(1);
            if (run_left_reg == LEN_W'(1)) begin
                run_active_next = 1'b0;
            end
        end
        if (s_accept) begin
            case (cmd.kind)
                CMD_LIT: begin
                    run_active_next = 1'b1;
                    run_lit_next    = 1'b1;
                    run_byte_next   = cmd.lit_byte;
                    run_left_next   = LEN_W'(1);
                end
                CMD_MATCH: begin
                    run_active_next = 1'b1;
                    run_lit_next    = 1'b0;
                    run_pos_next    = cmd.pos;
                    run_left_next   = cmd.len;
                end
                default: begin
                    run_active_next = run_active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_active_reg <= 1'b0;
        end else begin
            run_active_reg <= run_active_next;
        end
        run_lit_reg  <= run_lit_next;
        run_byte_reg <= run_byte_next;
        run_pos_reg  <= run_pos_next;
        run_left_reg <= run_left_next;
    end

    // History ring
    lzxd_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (pend_reg),
        .waddr (cursor_reg),
        .wdata (ring_byte),
        .re    (issue && !run_lit_reg),
        .raddr (run_pos_reg),
        .rdata (ram_rdata)
    );

    // Read-return stage; forward the byte written in the read cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= issue;
        end
        pend_last_reg <= (run_left_reg == LEN_W'(1));
        pend_lit_reg  <= run_lit_reg;
        pend_byte_reg <= run_byte_reg;
        pend_fwd_reg  <= pend_reg && (run_pos_reg == cursor_reg);
        pend_zero_reg <= !({1'b0, run_pos_reg} < fill_reg);
    end

    always_comb begin
        if (pend_lit_reg) begin
            ring_byte = pend_byte_reg;
        end else if (pend_fwd_reg) begin
            ring_byte = last_byte_reg;
        end else if (pend_zero_reg) begin
            ring_byte = 8'd0;
        end else begin
            ring_byte = ram_rdata;
        end
    end

    // Write cursor and fill count (entries at or above the fill read as zero)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            fill_reg   <= '0;
        end else if (pend_reg) begin
            cursor_reg <= cursor_reg + RING_AW'(1);
            if (fill_reg != FILL_W'(RING_DEPTH)) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
        if (pend_reg) begin
            last_byte_reg <= ring_byte;
        end
    end

    // Two-entry output queue
    assign fifo_push = pend_reg;
    assign fifo_pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wr_ptr_reg <= 1'b0;
            fifo_rd_ptr_reg <= 1'b0;
            fifo_count_reg  <= 2'd0;
        end else begin
            if (fifo_push) begin
                fifo_wr_ptr_reg <= !fifo_wr_ptr_reg;
            end
            if (fifo_pop) begin
                fifo_rd_ptr_reg <= !fifo_rd_ptr_reg;
            end
            if (fifo_push && !fifo_pop) begin
                fifo_count_reg <= fifo_count_reg + 2'd1;
            end else if (!fifo_push && fifo_pop) begin
                fifo_count_reg <= fifo_count_reg - 2'd1;
            end
        end
        if (fifo_push) begin
            fifo_byte_reg[fifo_wr_ptr_reg] <= ring_byte;
            fifo_last_reg[fifo_wr_ptr_reg] <= pend_last_reg;
        end
    end

    assign m_valid       = (fifo_count_reg != 2'd0);
    assign m_out_byte    = fifo_byte_reg[fifo_rd_ptr_reg];
    assign m_last_of_run = fifo_last_reg[fifo_rd_ptr_reg];

    // Checks
    `LZXD_ASSERT_IMPLY(a_queue_room, aclk, aresetn, fifo_push && fifo_count_reg == 2'd2, fifo_pop)
    `LZXD_ASSERT_IMPLY(a_run_nonempty, aclk, aresetn, run_active_reg, run_left_reg != '0)
    `LZXD_ASSERT_NEXT(a_lit_start, aclk, aresetn, s_accept && cmd.kind == CMD_LIT, run_active_reg && run_left_reg == LEN_W'(1))
    `LZXD_ASSERT_IMPLY(a_fill_cap, aclk, aresetn, 1'b1, fill_reg <= FILL_W'(RING_DEPTH))

endmodule
